FILE: rtl/xfc_pkg.sv
// ----------------------------------------------------------------------------
// xfc_pkg
// Shared types and constants for the XOR frame checker.
// ----------------------------------------------------------------------------
package xfc_pkg;

    localparam int unsigned POS_W     = 17;
    localparam int unsigned FLEN_W    = POS_W + 1;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned TDATA_W   = 64;

    localparam logic [POS_W-1:0]  POS_MAX        = {POS_W{1'b1}};
    localparam logic [POS_W-1:0]  PAYLOAD_START  = POS_W'(5);
    localparam logic [FLEN_W-1:0] FRAME_OVERHEAD = FLEN_W'(7);

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

    localparam logic [7:0]  HEAD_MARKER_RST = 8'hAA;
    localparam logic [7:0]  END_MARKER_RST  = 8'h55;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_MARKER       = 3'd2,
        ST_TOO_LONG     = 3'd3,
        ST_LEN_MISMATCH = 3'd4,
        ST_CHECKSUM     = 3'd5
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        t_status     status;
        logic [7:0]  address;
        logic [7:0]  function_code;
        logic [15:0] payload_length;
    } t_result;

endpackage

FILE: rtl/xfc_checker.sv
// ----------------------------------------------------------------------------
// xfc_checker
// Frame state, header capture, payload and verdict items; one byte per cycle while i_accept is high.
// ----------------------------------------------------------------------------
module xfc_checker import xfc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output logic                 o_res_valid,
    output t_result              o_res
);

    logic [7:0]       r_head_marker;
    logic [7:0]       r_end_marker;
    logic [15:0]      r_max_payload;

    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_xor;
    logic             r_head_ok;
    logic [7:0]       r_addr;
    logic [7:0]       r_func;
    logic [15:0]      r_len;

    logic             n_head_ok;
    logic [7:0]       n_addr;
    logic [7:0]       n_func;
    logic [15:0]      n_len;
    logic [FLEN_W-1:0] flen;
    logic [FLEN_W-1:0] need;
    logic [POS_W-1:0] pay_off;
    logic             pay_hit;
    t_status          status;

    always_comb begin
        n_head_ok = r_head_ok;
        n_addr    = r_addr;
        n_func    = r_func;
        n_len     = r_len;
        unique case (r_pos)
            POS_W'(0): n_head_ok = (i_byte == r_head_marker);
            POS_W'(1): n_addr = i_byte;
            POS_W'(2): n_func = i_byte;
            POS_W'(3): n_len[7:0] = i_byte;
            POS_W'(4): n_len[15:8] = i_byte;
            default: ;
        endcase
    end

    assign flen    = {1'b0, r_pos} + FLEN_W'(1);
    assign need    = FRAME_OVERHEAD + {2'b00, n_len};
    assign pay_off = r_pos - PAYLOAD_START;
    assign pay_hit = (r_pos >= PAYLOAD_START) && (pay_off < {1'b0, n_len});

    always_comb begin
        priority if (flen < FRAME_OVERHEAD) begin
            status = ST_SHORT;
        end else if (!n_head_ok || i_byte != r_end_marker) begin
            status = ST_MARKER;
        end else if (n_len > r_max_payload) begin
            status = ST_TOO_LONG;
        end else if (flen != need) begin
            status = ST_LEN_MISMATCH;
        end else if (r_xor != 8'd0) begin
            status = ST_CHECKSUM;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_res_valid          = i_last || pay_hit;
        o_res.kind           = i_last;
        o_res.payload_byte   = i_last ? 8'd0 : i_byte;
        o_res.payload_index  = i_last ? 16'd0 : pay_off[15:0];
        o_res.status         = i_last ? status : ST_OK;
        o_res.address        = n_addr;
        o_res.function_code  = n_func;
        o_res.payload_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_marker <= HEAD_MARKER_RST;
            r_end_marker  <= END_MARKER_RST;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEAD_MARKER: r_head_marker <= i_cfg_data[7:0];
                CFG_END_MARKER:  r_end_marker  <= i_cfg_data[7:0];
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_xor     <= '0;
            r_head_ok <= 1'b0;
            r_addr    <= '0;
            r_func    <= '0;
            r_len     <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_pos     <= '0;
                r_xor     <= '0;
                r_head_ok <= 1'b0;
                r_addr    <= '0;
                r_func    <= '0;
                r_len     <= '0;
            end else begin
                r_xor     <= r_xor ^ i_byte;
                r_head_ok <= n_head_ok;
                r_addr    <= n_addr;
                r_func    <= n_func;
                r_len     <= n_len;
                if (r_pos != POS_MAX) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_pos == '0 && r_xor == 8'd0 && !r_head_ok))
        else $error("frame state not cleared after verdict");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_last && r_pos != POS_MAX) |=> (r_pos == $past(r_pos) + POS_W'(1)))
        else $error("byte position did not advance");

    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_pos))
        else $error("byte position moved without an item");

    a_payload_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.kind) |-> (o_res.status == ST_OK))
        else $error("payload item carries a status");

endmodule

FILE: rtl/xfc_skid.sv
// ----------------------------------------------------------------------------
// xfc_skid
// Output register with one skid entry between checker and master stream.
// ----------------------------------------------------------------------------
module xfc_skid import xfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_pop_ready
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && i_pop_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held while output register empty");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !r_main_valid) |=> (r_main_valid && !r_skid_valid))
        else $error("item into empty stage not shown at output");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && pop) |=> (r_main_valid && !r_skid_valid))
        else $error("skid entry not moved forward");

endmodule

FILE: rtl/xor_frame_checker_core.sv
// ----------------------------------------------------------------------------
// xor_frame_checker_core
// Byte-serial frame checker: passes payload items on, gives a verdict item.
// ----------------------------------------------------------------------------
// Result items are registered: output register, or skid entry while it is held.
// Throughput: one byte per cycle while s_axis_tready is high; state updates per byte.
// The skid entry keeps s_axis_tready high while one result waits downstream.
// Reset (i_rst_n low, synchronous): clears the frame state and both output
// entries, and restores the marker and max payload registers to defaults.
// ----------------------------------------------------------------------------
module xor_frame_checker_core import xfc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
    input  logic                 s_axis_tlast,  // frame_last
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] payload_byte, [23:8] payload_index, [26:24] status, [34:27] address,
    // [42:35] function_code, [58:43] payload_length, [63:59] zero
    output logic [TDATA_W-1:0]   m_axis_tdata,
    output logic                 m_axis_tuser   // kind
);

    logic    accept;
    logic    res_valid;
    logic    skid_ready;
    t_result res;
    t_result out_res;

    assign s_axis_tready = skid_ready;
    assign accept        = s_axis_tvalid && skid_ready;

    xfc_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    xfc_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept && res_valid),
        .i_data      (res),
        .o_ready     (skid_ready),
        .o_valid     (m_axis_tvalid),
        .o_data      (out_res),
        .i_pop_ready (m_axis_tready)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {5'd0, out_res.payload_length, out_res.function_code,
                           out_res.address, out_res.status, out_res.payload_index,
                           out_res.payload_byte};

endmodule

FILE: bench/xfc_frame_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xfc_frame_scoreboard
// Watches both streams and the register port of the frame checker. Each
// accepted byte is run through a cycle-free model of the frame state, the
// payload and verdict items it causes are queued, and every item leaving the
// block is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module xfc_frame_scoreboard import xfc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
    input  logic                 s_axis_tlast,  // frame_last
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] payload_byte, [23:8] payload_index, [26:24] status, [34:27] address,
    // [42:35] function_code, [58:43] payload_length, [63:59] zero
    input  logic [TDATA_W-1:0]   m_axis_tdata,
    input  logic                 m_axis_tuser,  // kind
    output int                   o_fail_count,
    output int                   o_awaited
);

    logic [7:0]       head_reg;
    logic [7:0]       end_reg;
    logic [15:0]      max_reg;

    logic [POS_W-1:0] pos_q;
    logic [7:0]       xor_q;
    logic             head_ok_q;
    logic [7:0]       addr_q;
    logic [7:0]       func_q;
    logic [15:0]      len_q;

    t_result          frame_items_q[$];
    int               fails = 0;
    int               awaited_n = 0;

    assign o_fail_count = fails;
    assign o_awaited    = awaited_n;

    task automatic clear_frame();
        pos_q     = '0;
        xor_q     = '0;
        head_ok_q = 1'b0;
        addr_q    = '0;
        func_q    = '0;
        len_q     = '0;
    endtask

    task automatic track_byte(input logic [7:0] b, input logic last);
        logic [POS_W-1:0]  at;
        logic [FLEN_W-1:0] flen;
        t_status           st;
        t_result           r;
        at = pos_q;
        if (at == 0) begin
            head_ok_q = (b == head_reg);
        end else if (at == 1) begin
            addr_q = b;
        end else if (at == 2) begin
            func_q = b;
        end else if (at == 3) begin
            len_q[7:0] = b;
        end else if (at == 4) begin
            len_q[15:8] = b;
        end
        r                = '0;
        r.address        = addr_q;
        r.function_code  = func_q;
        r.payload_length = len_q;
        if (last) begin
            flen = FLEN_W'(at) + FLEN_W'(1);
            if (flen < FRAME_OVERHEAD) begin
                st = ST_SHORT;
            end else if (!head_ok_q || b != end_reg) begin
                st = ST_MARKER;
            end else if (len_q > max_reg) begin
                st = ST_TOO_LONG;
            end else if (flen != FRAME_OVERHEAD + FLEN_W'(len_q)) begin
                st = ST_LEN_MISMATCH;
            end else if (xor_q != 8'h00) begin
                st = ST_CHECKSUM;
            end else begin
                st = ST_OK;
            end
            r.kind   = 1'b1;
            r.status = st;
            frame_items_q.push_back(r);
            clear_frame();
        end else begin
            xor_q = xor_q ^ b;
            if (pos_q != POS_MAX) begin
                pos_q = pos_q + 1'b1;
            end
            if (at >= PAYLOAD_START && (at - PAYLOAD_START) < POS_W'(len_q)) begin
                r.kind          = 1'b0;
                r.payload_byte  = b;
                r.payload_index = 16'(at - PAYLOAD_START);
                r.status        = ST_OK;
                frame_items_q.push_back(r);
            end
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    task automatic compare_item(input logic [TDATA_W-1:0] d, input logic k);
        t_result want;
        if (frame_items_q.size() == 0) begin
            $error("unexpected item: tuser=%0b tdata=%h", k, d);
            fails++;
        end else begin
            want = frame_items_q.pop_front();
            check_field("kind", want.kind, k);
            check_field("payload_byte", want.payload_byte, d[7:0]);
            check_field("payload_index", want.payload_index, d[23:8]);
            check_field("status", want.status, d[26:24]);
            check_field("address", want.address, d[34:27]);
            check_field("function_code", want.function_code, d[42:35]);
            check_field("payload_length", want.payload_length, d[58:43]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_reg = HEAD_MARKER_RST;
            end_reg  = END_MARKER_RST;
            max_reg  = MAX_PAYLOAD_RST;
            clear_frame();
            frame_items_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                compare_item(m_axis_tdata, m_axis_tuser);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEAD_MARKER: head_reg = i_cfg_data[7:0];
                    CFG_END_MARKER:  end_reg  = i_cfg_data[7:0];
                    CFG_MAX_PAYLOAD: max_reg  = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                track_byte(s_axis_tdata, s_axis_tlast);
            end
        end
        awaited_n = frame_items_q.size();
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the XOR frame checker. Sends directed frames covering every
// status, then random frames under several marker and length settings. The
// sender works in bursts, the receiver stalls in changing patterns and
// sometimes holds off for a long stretch; the scoreboard judges every output
// item.
// ----------------------------------------------------------------------------
module tb_top import xfc_pkg::*; ();

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
    localparam int                   CYCLE_LIMIT = 1000000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tuser;

    int                   fails;
    int                   awaited;
    int                   cycle_count = 0;
    int                   bytes_sent = 0;
    int                   burst_left = 0;
    logic [7:0]           cur_head = HEAD_MARKER_RST;
    logic [7:0]           cur_end = END_MARKER_RST;
    logic [15:0]          cur_max = MAX_PAYLOAD_RST;

    int                   rx_cycle = 0;
    int                   hold_left = 0;
    int                   rx_mode = 0;
    int                   rx_mode_left = 0;

    always #1 i_clk = ~i_clk;

    xor_frame_checker_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    xfc_frame_scoreboard u_scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fails),
        .o_awaited     (awaited)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("xor_frame_checker_core regression: fail");
            $finish;
        end
    end

    // receiver: changing stall patterns, with long hold-offs to back the block up
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_cycle == 1500 || rx_cycle == 6000 || $urandom_range(0, 4999) == 0) begin
            hold_left     <= $urandom_range(120, 300);
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(10, 200);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((rx_cycle % 5) != 0);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left != 0) begin
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] head, addr, func, input logic [15:0] len,
                              input int n_pay, input logic [7:0] tail, sum_flip);
        logic [7:0] acc;
        logic [7:0] pb;
        int         j;
        acc = head ^ addr ^ func ^ len[7:0] ^ len[15:8];
        send_byte(head, 1'b0);
        send_byte(addr, 1'b0);
        send_byte(func, 1'b0);
        send_byte(len[7:0], 1'b0);
        send_byte(len[15:8], 1'b0);
        for (j = 0; j < n_pay; j++) begin
            pb  = 8'($urandom);
            acc = acc ^ pb;
            send_byte(pb, 1'b0);
        end
        send_byte(acc ^ sum_flip, 1'b0);
        send_byte(tail, 1'b1);
    endtask

    task automatic send_noise(input int n);
        int j;
        for (j = 0; j < n; j++) begin
            send_byte(8'($urandom), j == n - 1);
        end
    endtask

    task automatic send_random_frame();
        int         pick;
        int         cap;
        int         len;
        int         n_pay;
        logic [7:0] flip;
        logic [7:0] addr;
        logic [7:0] func;
        pick = $urandom_range(0, 99);
        cap  = (cur_max < 12) ? cur_max : 12;
        if ($urandom_range(0, 9) == 0) begin
            cap = (cur_max < 60) ? cur_max : 60;
        end
        len  = $urandom_range(0, cap);
        flip = 8'($urandom_range(1, 255));
        addr = 8'($urandom);
        func = 8'($urandom);
        if (pick < 75) begin
            send_frame(cur_head, addr, func, 16'(len), len, cur_end, 8'h00);
        end else if (pick < 80) begin
            send_noise($urandom_range(1, 10));
        end else if (pick < 84) begin
            send_frame(cur_head ^ flip, addr, func, 16'(len), len, cur_end, 8'h00);
        end else if (pick < 88) begin
            send_frame(cur_head, addr, func, 16'(len), len, cur_end ^ flip, 8'h00);
        end else if (pick < 92) begin
            send_frame(cur_head, addr, func, 16'(len), len, cur_end, flip);
        end else if (pick < 96) begin
            if (len > 0 && $urandom_range(0, 1) == 1) begin
                n_pay = len - int'($urandom_range(1, len));
            end else begin
                n_pay = len + int'($urandom_range(1, 4));
            end
            send_frame(cur_head, addr, func, 16'(len), n_pay, cur_end, 8'h00);
        end else if (cur_max != 16'hFFFF) begin
            len = int'(cur_max) + 1 + int'($urandom_range(0, 1000));
            if (len > 65535 || $urandom_range(0, 3) == 0) begin
                len = 65535;
            end
            send_frame(cur_head, addr, func, 16'(len), $urandom_range(0, 6), cur_end, 8'h00);
        end else begin
            send_frame(cur_head, addr, func, 16'hFFFF, 20, cur_end, 8'h00);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        repeat (3) @(posedge i_clk);
        while (awaited != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] head, tail, input logic [15:0] maxp);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HEAD_MARKER;
        i_cfg_data  <= {8'($urandom), head};
        @(posedge i_clk);
        i_cfg_index <= CFG_END_MARKER;
        i_cfg_data  <= {8'($urandom), tail};
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_PAYLOAD;
        i_cfg_data  <= maxp;
        @(posedge i_clk);
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_head = head;
        cur_end  = tail;
        cur_max  = maxp;
    endtask

    initial begin
        int phase;
        int phase_end;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(HEAD_MARKER_RST, 8'h00, 8'hFF, 16'd0, 0, END_MARKER_RST, 8'h00);
        send_frame(HEAD_MARKER_RST, 8'hFF, 8'h00, 16'd1, 1, END_MARKER_RST, 8'h00);
        send_byte(8'hFF, 1'b1);
        send_noise(6);
        send_frame(8'h00, 8'h12, 8'h34, 16'd0, 0, END_MARKER_RST, 8'h00);
        send_frame(HEAD_MARKER_RST, 8'h12, 8'h34, 16'd0, 0, 8'h00, 8'h00);
        send_frame(HEAD_MARKER_RST, 8'h56, 8'h78, 16'd0, 0, END_MARKER_RST, 8'h80);
        send_frame(HEAD_MARKER_RST, 8'h9A, 8'hBC, 16'd2, 1, END_MARKER_RST, 8'h00);
        send_frame(HEAD_MARKER_RST, 8'hDE, 8'hF0, 16'h0101, 3, END_MARKER_RST, 8'h00);
        settle();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: program_regs(8'h00, 8'hFF, 16'h0000);
                1: program_regs(8'hFF, 8'h00, 16'hFFFF);
                2: program_regs(8'($urandom), 8'($urandom), 16'd7);
                default: program_regs(8'($urandom), 8'($urandom),
                                      16'($urandom_range(8, 300)));
            endcase
            phase_end = bytes_sent + 395;
            while (bytes_sent < phase_end) begin
                send_random_frame();
            end
            settle();
        end

        if (fails == 0 && awaited == 0) begin
            $display("xor_frame_checker_core regression: pass");
        end else begin
            $display("xor_frame_checker_core regression: fail");
        end
        $finish;
    end

endmodule
